/* hw/rtl/nsd_pkg.sv */
// Package for the symbol name decoder: constants, result type and alphabet lookup.
`timescale 1ns / 1ps
package nsd_pkg;

  localparam int CHAR_BITS       = 8;
  localparam int NID_BITS        = 64;
  localparam int ID_BITS         = 16;
  localparam int DIGIT_BITS      = 6;
  localparam int LAST_DIGIT_BITS = 4;
  localparam int FIELD_COUNT     = 3;

  localparam logic [3:0] NID_DIGITS = 4'd11;
  localparam logic [3:0] ID_DIGITS  = 4'd3;

  localparam logic [1:0] FIELD_NID  = 2'd0;
  localparam logic [1:0] FIELD_LIB  = 2'd1;
  localparam logic [1:0] FIELD_MOD  = 2'd2;
  localparam logic [1:0] FIELD_DONE = 2'd3;

  localparam logic [CHAR_BITS-1:0] HASH_CODE = 8'h23;

  // One decoded name.
  typedef struct packed {
    logic [NID_BITS-1:0] nid_value;
    logic [ID_BITS-1:0]  library_id;
    logic [ID_BITS-1:0]  module_id;
    logic                bad_char;
    logic                overlong;
    logic                fields_missing;
  } result_t;

  // Alphabet lookup: bit 6 is set when the byte is in the alphabet,
  // bits 5:0 give its index.
  function automatic logic [DIGIT_BITS:0] alpha_index(input logic [CHAR_BITS-1:0] c);
    logic [DIGIT_BITS:0] r;
    r = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = {1'b1, 6'(c - 8'h41)};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (c == 8'h2D) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/nsd_if.sv */
// Stream interfaces for the symbol name decoder: character words in, result words out.
`timescale 1ns / 1ps
interface nsd_char_if;
  logic                          valid;
  logic                          ready;
  logic [nsd_pkg::CHAR_BITS-1:0] char_code;
  logic                          is_final;

  modport source (output valid, output char_code, output is_final, input ready);
  modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

interface nsd_result_if;
  logic                         valid;
  logic                         ready;
  logic [nsd_pkg::NID_BITS-1:0] nid_value;
  logic [nsd_pkg::ID_BITS-1:0]  library_id;
  logic [nsd_pkg::ID_BITS-1:0]  module_id;
  logic                         bad_char;
  logic                         overlong;
  logic                         fields_missing;

  modport source (output valid, output nid_value, output library_id, output module_id,
                  output bad_char, output overlong, output fields_missing, input ready);
  modport sink   (input valid, input nid_value, input library_id, input module_id,
                  input bad_char, input overlong, input fields_missing, output ready);
endinterface

/* hw/rtl/nsd_field_accum.sv */
// Field accumulator: per-character decode state and the result register.
`timescale 1ns / 1ps
module nsd_field_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [nsd_pkg::CHAR_BITS-1:0] char_code,
  input  logic                          is_final,
  output logic                          slot_free,
  output logic                          res_valid,
  input  logic                          res_ready,
  output nsd_pkg::result_t              res
);
  import nsd_pkg::*;

  logic [1:0]          field_number, field_number_next;
  logic [3:0]          digit_count, digit_count_next;
  logic [NID_BITS-1:0] nid_accum, nid_accum_next;
  logic [ID_BITS-1:0]  lib_accum, lib_accum_next;
  logic [ID_BITS-1:0]  mod_accum, mod_accum_next;
  logic                field_halted, field_halted_next;
  logic                bad_seen, bad_seen_next;
  logic                long_seen, long_seen_next;

  logic [DIGIT_BITS:0]   lookup;
  logic [DIGIT_BITS-1:0] idx;
  logic [3:0]            full;
  logic                  last;
  logic [ID_BITS-1:0]    id_sel, id_push;

  assign lookup = alpha_index(char_code);
  assign idx    = lookup[DIGIT_BITS-1:0];
  assign full   = (field_number == FIELD_NID) ? NID_DIGITS : ID_DIGITS;
  assign last   = (digit_count == full - 4'd1);
  assign id_sel = (field_number == FIELD_LIB) ? lib_accum : mod_accum;
  assign id_push = last ? {id_sel[ID_BITS-LAST_DIGIT_BITS-1:0],
                           idx[DIGIT_BITS-1:DIGIT_BITS-LAST_DIGIT_BITS]}
                        : {id_sel[ID_BITS-DIGIT_BITS-1:0], idx};

  // Next decode state for the character in the input register.
  always_comb begin
    field_number_next = field_number;
    digit_count_next  = digit_count;
    nid_accum_next    = nid_accum;
    lib_accum_next    = lib_accum;
    mod_accum_next    = mod_accum;
    field_halted_next = field_halted;
    bad_seen_next     = bad_seen;
    long_seen_next    = long_seen;
    if (field_number != FIELD_DONE) begin
      if (char_code == HASH_CODE) begin
        field_number_next = field_number + 2'd1;
        digit_count_next  = 4'd0;
        field_halted_next = 1'b0;
      end else if (!field_halted) begin
        if (!lookup[DIGIT_BITS]) begin
          bad_seen_next     = 1'b1;
          field_halted_next = 1'b1;
        end else if (digit_count >= full) begin
          long_seen_next = 1'b1;
        end else begin
          digit_count_next = digit_count + 4'd1;
          case (field_number)
            FIELD_NID: begin
              nid_accum_next = last
                ? {nid_accum[NID_BITS-LAST_DIGIT_BITS-1:0],
                   idx[DIGIT_BITS-1:DIGIT_BITS-LAST_DIGIT_BITS]}
                : {nid_accum[NID_BITS-DIGIT_BITS-1:0], idx};
            end
            FIELD_LIB: lib_accum_next = id_push;
            default:   mod_accum_next = id_push;
          endcase
        end
      end
    end
  end

  assign slot_free = !res_valid || res_ready;

  // Decode state: cleared after each final character.
  always_ff @(posedge clk) begin
    if (rst || (take && is_final)) begin
      field_number <= FIELD_NID;
      digit_count  <= 4'd0;
      nid_accum    <= '0;
      lib_accum    <= '0;
      mod_accum    <= '0;
      field_halted <= 1'b0;
      bad_seen     <= 1'b0;
      long_seen    <= 1'b0;
    end else if (take) begin
      field_number <= field_number_next;
      digit_count  <= digit_count_next;
      nid_accum    <= nid_accum_next;
      lib_accum    <= lib_accum_next;
      mod_accum    <= mod_accum_next;
      field_halted <= field_halted_next;
      bad_seen     <= bad_seen_next;
      long_seen    <= long_seen_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && is_final) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload, loaded on the final character of a name.
  always_ff @(posedge clk) begin
    if (take && is_final) begin
      res.nid_value      <= nid_accum_next;
      res.library_id     <= lib_accum_next;
      res.module_id      <= mod_accum_next;
      res.bad_char       <= bad_seen_next;
      res.overlong       <= long_seen_next;
      res.fields_missing <= (field_number_next != FIELD_DONE);
    end
  end

endmodule

/* hw/rtl/nid_symbol_name_decoder_core.sv */
// Top level of the symbol name decoder: input register and result channel.
//
// Usage:
//   chars carries one byte of an encoded name per word, with is_final set
//   on the last byte. Names have the form nid#lib#module#, each byte from
//   the alphabet A-Z a-z 0-9 + -.
//   results carries one word per name: the 64-bit nid, the 16-bit library
//   and module ids, and the bad_char, overlong and fields_missing flags.
//   Throughput: one byte per cycle while no final byte waits for the result
//   slot; the field accumulators compute the next state combinationally
//   between the input register and the state registers. Result path: an
//   accepted final byte passes the input register, then the result register,
//   which holds the result word until it is taken.
//   Reset: rst is synchronous and active high; it empties the input and
//   result registers and returns the decoder to the start of a name.
//   Stall: a waiting result is held stable until taken. Non-final bytes
//   keep flowing; a final byte waits in the input register only while the
//   previous result has not been taken.
`timescale 1ns / 1ps
module nid_symbol_name_decoder_core (
  input  logic                clk,
  input  logic                rst,
  nsd_char_if.sink            chars,
  nsd_result_if.source        results
);
  import nsd_pkg::*;

  logic                 in_valid;
  logic [CHAR_BITS-1:0] in_char;
  logic                 in_final;
  logic                 take;
  logic                 slot_free;
  result_t              res;

  // The held byte moves on unless it is final and the result slot is full.
  assign take        = in_valid && (!in_final || slot_free);
  assign chars.ready = !in_valid || take;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_char  <= chars.char_code;
      in_final <= chars.is_final;
    end
  end

  nsd_field_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .char_code (in_char),
    .is_final  (in_final),
    .slot_free (slot_free),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res       (res)
  );

  assign results.nid_value      = res.nid_value;
  assign results.library_id     = res.library_id;
  assign results.module_id      = res.module_id;
  assign results.bad_char       = res.bad_char;
  assign results.overlong       = res.overlong;
  assign results.fields_missing = res.fields_missing;

endmodule
